>>> hw/rtl/mte_pkg.sv
package mte_pkg;

   localparam logic        CMD_ENCAP  = 1'b0;
   localparam logic        CMD_DECAP  = 1'b1;
   localparam logic        DIR_WIRE   = 1'b0;
   localparam logic        DIR_TUNNEL = 1'b1;

   localparam logic [2:0]  REG_DEST_MAC              = 3'd0;
   localparam logic [2:0]  REG_SOURCE_MAC            = 3'd1;
   localparam logic [2:0]  REG_PUSH_LABEL            = 3'd2;
   localparam logic [2:0]  REG_PUSH_TRANSPORT_LABEL  = 3'd3;
   localparam logic [2:0]  REG_MATCH_LABEL           = 3'd4;
   localparam logic [2:0]  REG_MATCH_TRANSPORT_LABEL = 3'd5;

   localparam int          CSR_INDEX_W = 3;
   localparam int          CSR_DATA_W  = 48;

   localparam logic [15:0] ETHERTYPE_MPLS = 16'h8847;
   localparam logic [7:0]  LABEL_TTL      = 8'hff;
   localparam logic [4:0]  HDR_LEN        = 5'd14;
   localparam logic [4:0]  ENTRY_LEN      = 5'd4;
   localparam logic [4:0]  PAYLOAD_POS    = 5'd22;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic       direction;
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [19:0] push_label;
      logic [19:0] push_transport_label;
      logic [19:0] match_label;
      logic [19:0] match_transport_label;
   } cfg_type;

   typedef struct packed {
      logic       hdr;
      logic       direction;
      logic [7:0] data_byte;
      logic       last;
   } job_type;

   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0: b = mac[47:40];
         3'd1: b = mac[39:32];
         3'd2: b = mac[31:24];
         3'd3: b = mac[23:16];
         3'd4: b = mac[15:8];
         3'd5: b = mac[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] entry_byte(input logic [19:0] label, input logic bos,
                                             input logic [1:0] k);
      logic [31:0] e;
      logic [7:0]  b;
      e = {label, 3'b000, bos, LABEL_TTL};
      case (k)
         2'd0: b = e[31:24];
         2'd1: b = e[23:16];
         2'd2: b = e[15:8];
         default: b = e[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> hw/rtl/mte_front.sv
module mte_front (
   input  logic              clock,
   input  logic              reset,
   input  mte_pkg::cfg_type  cfg,
   input  logic              req_push,
   input  mte_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              job_push,
   output mte_pkg::job_type  job
);

   logic        encap_mid_ff, encap_mid_in;
   logic [4:0]  pos_ff, pos_in;
   logic [23:0] shift_ff, shift_in;
   logic        drop_ff, drop_in;

   logic        accept;
   logic        trans;
   logic [4:0]  svc_at;
   logic [4:0]  payload_at;
   logic [23:0] shifted;
   logic [19:0] label;

   assign accept     = req_push && !q_full;
   assign trans      = cfg.match_transport_label != 20'd0;
   assign svc_at     = trans ? 5'(mte_pkg::HDR_LEN + mte_pkg::ENTRY_LEN) : mte_pkg::HDR_LEN;
   assign payload_at = 5'(svc_at + mte_pkg::ENTRY_LEN);
   assign shifted    = {shift_ff[15:0], req_data.data_byte};
   assign label      = shifted[23:4];

   always_comb begin
      encap_mid_in  = encap_mid_ff;
      pos_in        = pos_ff;
      shift_in      = shift_ff;
      drop_in       = drop_ff;
      job_push      = 1'b0;
      job.hdr       = 1'b0;
      job.direction = mte_pkg::DIR_WIRE;
      job.data_byte = req_data.data_byte;
      job.last      = req_data.end_of_packet;
      if (accept) begin
         if (req_data.cmd == mte_pkg::CMD_ENCAP) begin
            job_push     = 1'b1;
            job.hdr      = !encap_mid_ff;
            encap_mid_in = !req_data.end_of_packet;
         end else begin
            job.direction = mte_pkg::DIR_TUNNEL;
            if (pos_ff >= payload_at) begin
               job_push = !drop_ff;
            end else begin
               shift_in = shifted;
               if (trans && pos_ff == 5'(mte_pkg::HDR_LEN + 5'd2)
                   && label != cfg.match_transport_label) begin
                  drop_in = 1'b1;
               end
               if (pos_ff == 5'(svc_at + 5'd2) && label != cfg.match_label) begin
                  drop_in = 1'b1;
               end
               pos_in = 5'(pos_ff + 5'd1);
            end
            if (req_data.end_of_packet) begin
               pos_in   = 5'd0;
               shift_in = 24'd0;
               drop_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encap_mid_ff <= 1'b0;
         pos_ff       <= 5'd0;
         shift_ff     <= 24'd0;
         drop_ff      <= 1'b0;
      end else begin
         encap_mid_ff <= encap_mid_in;
         pos_ff       <= pos_in;
         shift_ff     <= shift_in;
         drop_ff      <= drop_in;
      end
   end

endmodule

>>> hw/rtl/mte_queue.sv
module mte_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mte_pkg::job_type  push_data,
   output logic              full,
   input  logic              pop,
   output mte_pkg::job_type  head,
   output logic              empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mte_pkg::job_type slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CW'(DEPTH);
   assign empty   = count_ff == CW'(0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : AW'(wr_ptr_ff + AW'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : AW'(rd_ptr_ff + AW'(1));
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + CW'(1));
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/mte_back.sv
module mte_back (
   input  logic              clock,
   input  logic              reset,
   input  mte_pkg::cfg_type  cfg,
   input  mte_pkg::job_type  head,
   input  logic              head_valid,
   output logic              head_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mte_pkg::rsp_type  rsp_data
);

   logic             out_valid_ff, out_valid_in;
   mte_pkg::rsp_type out_ff, out_in;
   logic [4:0]       pos_ff, pos_in;

   logic             advance;
   logic             trans;
   logic [4:0]       eff;
   logic [7:0]       byte_sel;
   logic [1:0]       ek;

   assign advance = !out_valid_ff || rsp_pop;
   assign trans   = cfg.push_transport_label != 20'd0;
   assign ek      = 2'(eff[1:0] + 2'd2);

   always_comb begin
      if (!head.hdr) begin
         eff = mte_pkg::PAYLOAD_POS;
      end else if (!trans && pos_ff >= mte_pkg::HDR_LEN) begin
         eff = 5'(pos_ff + mte_pkg::ENTRY_LEN);
      end else begin
         eff = pos_ff;
      end
   end

   always_comb begin
      case (eff)
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: begin
            byte_sel = mte_pkg::mac_byte(cfg.dest_mac, eff[2:0]);
         end
         5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11: begin
            byte_sel = mte_pkg::mac_byte(cfg.source_mac, 3'(eff - 5'd6));
         end
         5'd12: byte_sel = mte_pkg::ETHERTYPE_MPLS[15:8];
         5'd13: byte_sel = mte_pkg::ETHERTYPE_MPLS[7:0];
         5'd14, 5'd15, 5'd16, 5'd17: begin
            byte_sel = mte_pkg::entry_byte(cfg.push_transport_label, 1'b0, ek);
         end
         5'd18, 5'd19, 5'd20, 5'd21: begin
            byte_sel = mte_pkg::entry_byte(cfg.push_label, 1'b1, ek);
         end
         default: byte_sel = head.data_byte;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      pos_in       = pos_ff;
      head_pop     = 1'b0;
      if (advance) begin
         out_valid_in = head_valid;
         if (head_valid) begin
            out_in.direction = head.direction;
            out_in.out_byte  = byte_sel;
            out_in.out_last  = (eff == mte_pkg::PAYLOAD_POS) && head.last;
            if (eff == mte_pkg::PAYLOAD_POS) begin
               head_pop = 1'b1;
               pos_in   = 5'd0;
            end else begin
               pos_in = 5'(pos_ff + 5'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pos_ff       <= 5'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> hw/rtl/mpls_tunnel_encap_decap.sv
// MPLS tunnel byte stream, label push toward the wire and label pop toward the tunnel.
// Input channel: req_push/req_full carry one byte item (cmd, data_byte, end_of_packet).
// cmd selects encapsulation (0) or decapsulation (1); the two directions keep
// separate state and may be interleaved byte by byte.
// Result channel: rsp_empty/rsp_pop present the oldest result item (direction,
// out_byte, out_last); pop it while rsp_empty is low.
// Path: with nothing ahead of it, the first result item of an accepted item is
// registered in a job queue slot and then in the output register on the result ports.
// Throughput: one result item per cycle while the receiver pops. A decap byte yields
// at most one item and a mid-packet encap byte one; the first encap byte of a packet
// yields 19 or 23, emitted one per cycle by the header sequencer in the header burst.
// The job queue (QUEUE_DEPTH entries) holds accepted bytes during that burst;
// req_full rises only when it fills.
// When the receiver stalls, the output register holds its item, the sequencer
// waits, and the queue fills until req_full stops the sender.
// Reset: synchronous, active high; clears packet state, config, queue pointers/count;
// not data registers. Configuration registers are written through csr_we/csr_index/
// csr_wdata and should change only while no item is in flight.
module mpls_tunnel_encap_decap #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  mte_pkg::req_type                    req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output mte_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [mte_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mte_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   mte_pkg::cfg_type cfg_ff, cfg_in;
   mte_pkg::job_type job, head;
   logic             job_push, q_full, q_empty, head_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mte_pkg::REG_DEST_MAC:              cfg_in.dest_mac = csr_wdata;
            mte_pkg::REG_SOURCE_MAC:            cfg_in.source_mac = csr_wdata;
            mte_pkg::REG_PUSH_LABEL:            cfg_in.push_label = csr_wdata[19:0];
            mte_pkg::REG_PUSH_TRANSPORT_LABEL:  cfg_in.push_transport_label = csr_wdata[19:0];
            mte_pkg::REG_MATCH_LABEL:           cfg_in.match_label = csr_wdata[19:0];
            mte_pkg::REG_MATCH_TRANSPORT_LABEL: cfg_in.match_transport_label = csr_wdata[19:0];
            default:                            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = q_full;

   mte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .job_push (job_push),
      .job      (job)
   );

   mte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job),
      .full      (q_full),
      .pop       (head_pop),
      .head      (head),
      .empty     (q_empty)
   );

   mte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .head_valid (!q_empty),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

>>> hw/rtl/mte_checker.sv
module mte_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input mte_pkg::req_type req_data,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input mte_pkg::rsp_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("outputs not cleared after reset");

   a_encap_reaches_output: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full && req_data.cmd == mte_pkg::CMD_ENCAP |=> ##1 !rsp_empty)
      else $error("encap item produced no result in time");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result item withdrawn");

   a_result_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_data))
      else $error("waiting result item changed");

endmodule

bind mpls_tunnel_encap_decap mte_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

>>> sim/tb_mpls_tunnel_encap_decap.sv
module tb_mpls_tunnel_encap_decap;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_SETTLE = 16;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   mte_pkg::req_type                req_data = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   mte_pkg::rsp_type                rsp_data;
   logic                            csr_we = 1'b0;
   logic [mte_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mte_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   mte_pkg::cfg_type tun_cfg = '0;
   logic             enc_mid = 1'b0;
   logic [4:0]       dec_pos = '0;
   logic [23:0]      dec_shift = '0;
   logic             dec_drop = 1'b0;

   mte_pkg::rsp_type expected_bytes[$];
   mte_pkg::req_type enc_q[$];
   mte_pkg::req_type dec_q[$];
   mte_pkg::rsp_type want;
   int               errors = 0;
   int               items_sent = 0;
   int               cycle_count = 0;
   bit               quiet = 1'b0;

   mpls_tunnel_encap_decap u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result item %h", rsp_data);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.direction !== want.direction) begin
                  $error("direction: expected %0d, actual %0d", want.direction,
                         rsp_data.direction);
                  errors++;
               end
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", want.out_byte,
                         rsp_data.out_byte);
                  errors++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last: expected %0d, actual %0d", want.out_last,
                         rsp_data.out_last);
                  errors++;
               end
            end
         end
         rsp_pop <= quiet || ($urandom_range(0, 99) >= 10);
      end
   end

   function automatic mte_pkg::req_type make_req(logic cmd, logic [7:0] b, logic eop);
      mte_pkg::req_type r;
      r.cmd = cmd;
      r.data_byte = b;
      r.end_of_packet = eop;
      return r;
   endfunction

   function automatic void queue_byte(logic dir, logic [7:0] b, logic last);
      mte_pkg::rsp_type r;
      r.direction = dir;
      r.out_byte = b;
      r.out_last = last;
      expected_bytes.push_back(r);
   endfunction

   function automatic void queue_entry(logic [19:0] label, logic bos);
      logic [31:0] e;
      e = {label, 3'b000, bos, mte_pkg::LABEL_TTL};
      for (int k = 3; k >= 0; k--) queue_byte(mte_pkg::DIR_WIRE, e[8*k +: 8], 1'b0);
   endfunction

   function automatic void predict_tunnel(mte_pkg::req_type item);
      logic        trans;
      logic [4:0]  svc_at;
      logic [4:0]  pay_at;
      logic [19:0] lbl;
      if (item.cmd == mte_pkg::CMD_ENCAP) begin
         if (!enc_mid) begin
            for (int k = 5; k >= 0; k--)
               queue_byte(mte_pkg::DIR_WIRE, tun_cfg.dest_mac[8*k +: 8], 1'b0);
            for (int k = 5; k >= 0; k--)
               queue_byte(mte_pkg::DIR_WIRE, tun_cfg.source_mac[8*k +: 8], 1'b0);
            queue_byte(mte_pkg::DIR_WIRE, mte_pkg::ETHERTYPE_MPLS[15:8], 1'b0);
            queue_byte(mte_pkg::DIR_WIRE, mte_pkg::ETHERTYPE_MPLS[7:0], 1'b0);
            if (tun_cfg.push_transport_label != 0)
               queue_entry(tun_cfg.push_transport_label, 1'b0);
            queue_entry(tun_cfg.push_label, 1'b1);
         end
         queue_byte(mte_pkg::DIR_WIRE, item.data_byte, item.end_of_packet);
         enc_mid = !item.end_of_packet;
      end else begin
         trans = (tun_cfg.match_transport_label != 0);
         svc_at = trans ? mte_pkg::HDR_LEN + mte_pkg::ENTRY_LEN : mte_pkg::HDR_LEN;
         pay_at = svc_at + mte_pkg::ENTRY_LEN;
         if (dec_pos >= pay_at) begin
            if (!dec_drop) queue_byte(mte_pkg::DIR_TUNNEL, item.data_byte, item.end_of_packet);
         end else begin
            dec_shift = {dec_shift[15:0], item.data_byte};
            lbl = dec_shift[23:4];
            if (trans && dec_pos == mte_pkg::HDR_LEN + 5'd2
                && lbl != tun_cfg.match_transport_label)
               dec_drop = 1'b1;
            if (dec_pos == svc_at + 5'd2 && lbl != tun_cfg.match_label) dec_drop = 1'b1;
            dec_pos = dec_pos + 5'd1;
         end
         if (item.end_of_packet) begin
            dec_pos = '0;
            dec_shift = '0;
            dec_drop = 1'b0;
         end
      end
   endfunction

   task automatic send_item(input mte_pkg::req_type item);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 10) gap = 1;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      predict_tunnel(item);
      items_sent++;
   endtask

   task automatic settle_idle();
      req_push <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [47:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         mte_pkg::REG_DEST_MAC:              tun_cfg.dest_mac = value;
         mte_pkg::REG_SOURCE_MAC:            tun_cfg.source_mac = value;
         mte_pkg::REG_PUSH_LABEL:            tun_cfg.push_label = value[19:0];
         mte_pkg::REG_PUSH_TRANSPORT_LABEL:  tun_cfg.push_transport_label = value[19:0];
         mte_pkg::REG_MATCH_LABEL:           tun_cfg.match_label = value[19:0];
         mte_pkg::REG_MATCH_TRANSPORT_LABEL: tun_cfg.match_transport_label = value[19:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input mte_pkg::cfg_type c);
      logic [47:0] junk;
      junk = 48'({$urandom, $urandom});
      settle_idle();
      write_csr(mte_pkg::REG_DEST_MAC, c.dest_mac);
      write_csr(mte_pkg::REG_SOURCE_MAC, c.source_mac);
      write_csr(mte_pkg::REG_PUSH_LABEL, {junk[47:20], c.push_label});
      write_csr(mte_pkg::REG_PUSH_TRANSPORT_LABEL, {junk[46:19], c.push_transport_label});
      write_csr(mte_pkg::REG_MATCH_LABEL, {junk[45:18], c.match_label});
      write_csr(mte_pkg::REG_MATCH_TRANSPORT_LABEL, {junk[44:17], c.match_transport_label});
      csr_we <= 1'b0;
   endtask

   function automatic mte_pkg::cfg_type random_cfg(bit with_trans);
      mte_pkg::cfg_type c;
      c.dest_mac = 48'({$urandom, $urandom});
      c.source_mac = 48'({$urandom, $urandom});
      c.push_label = 20'($urandom_range(0, 20'hfffff));
      c.push_transport_label = $urandom_range(0, 1) ? 20'($urandom_range(1, 20'hfffff))
                                                    : 20'h0;
      c.match_label = 20'($urandom_range(0, 20'hfffff));
      c.match_transport_label = with_trans ? 20'($urandom_range(1, 20'hfffff)) : 20'h0;
      return c;
   endfunction

   function automatic void add_encap(int len);
      for (int i = 0; i < len; i++)
         enc_q.push_back(make_req(mte_pkg::CMD_ENCAP, 8'($urandom_range(0, 255)),
                                  i == len - 1));
   endfunction

   function automatic void add_decap(bit with_trans, logic [19:0] tl, logic [19:0] sl,
                                     int pay_len, int cut);
      logic [7:0]  bytes[$];
      logic [31:0] e;
      int          n;
      for (int i = 0; i < 14; i++) bytes.push_back(8'($urandom_range(0, 255)));
      if (with_trans) begin
         e = {tl, 12'($urandom_range(0, 4095))};
         for (int k = 3; k >= 0; k--) bytes.push_back(e[8*k +: 8]);
      end
      e = {sl, 12'($urandom_range(0, 4095))};
      for (int k = 3; k >= 0; k--) bytes.push_back(e[8*k +: 8]);
      for (int i = 0; i < pay_len; i++) bytes.push_back(8'($urandom_range(0, 255)));
      n = (cut >= 0 && cut < bytes.size()) ? cut + 1 : bytes.size();
      for (int i = 0; i < n; i++)
         dec_q.push_back(make_req(mte_pkg::CMD_DECAP, bytes[i], i == n - 1));
   endfunction

   function automatic void add_noise(int len);
      for (int i = 0; i < len; i++)
         dec_q.push_back(make_req(mte_pkg::CMD_DECAP, 8'($urandom_range(0, 255)),
                                  i == len - 1 || $urandom_range(0, 3) == 0));
   endfunction

   task automatic flush_streams();
      while (enc_q.size() != 0 || dec_q.size() != 0) begin
         if (dec_q.size() == 0 || (enc_q.size() != 0 && $urandom_range(0, 1)))
            send_item(enc_q.pop_front());
         else
            send_item(dec_q.pop_front());
      end
   endtask

   task automatic test_default_config();
      send_item(make_req(mte_pkg::CMD_ENCAP, 8'h00, 1'b1));
   endtask

   task automatic test_encap_transport();
      mte_pkg::cfg_type c;
      c = '0;
      c.dest_mac = '1;
      c.push_label = '1;
      c.push_transport_label = '1;
      load_config(c);
      send_item(make_req(mte_pkg::CMD_ENCAP, 8'hff, 1'b0));
      send_item(make_req(mte_pkg::CMD_ENCAP, 8'h80, 1'b1));
   endtask

   task automatic test_decap_short_frame();
      add_decap(1'b0, 20'h0, tun_cfg.match_label, 0, 2);
      flush_streams();
   endtask

   task automatic test_empty_payload_interleaved();
      add_decap(1'b0, 20'h0, tun_cfg.match_label, 0, -1);
      add_encap(2);
      flush_streams();
   endtask

   task automatic test_random_traffic(input mte_pkg::cfg_type c, input bit no_idle,
                                      input int count);
      int          start;
      int          pick;
      bit          trans;
      logic [19:0] tl;
      logic [19:0] sl;
      load_config(c);
      quiet = no_idle;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(0, 99);
         trans = (tun_cfg.match_transport_label != 0);
         tl = tun_cfg.match_transport_label;
         sl = tun_cfg.match_label;
         if (pick < 60) begin
            add_decap(trans, tl, sl, $urandom_range(0, 6), -1);
         end else if (pick < 75) begin
            case ($urandom_range(0, 2))
               0: tl = tl ^ (20'h1 << $urandom_range(0, 19));
               1: sl = sl ^ (20'h1 << $urandom_range(0, 19));
               default: trans = !trans;
            endcase
            add_decap(trans, tl, sl, $urandom_range(0, 6), -1);
         end else if (pick < 85) begin
            add_decap(trans, tl, sl, 2, $urandom_range(0, 20));
         end else begin
            add_noise($urandom_range(1, 4));
         end
         if ($urandom_range(0, 1)) add_encap($urandom_range(1, 5));
         flush_streams();
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_default_config();
      test_encap_transport();
      test_decap_short_frame();
      test_empty_payload_interleaved();
      test_random_traffic(random_cfg(1'b1), 1'b0, 25);
      test_random_traffic('1, 1'b1, 25);
      test_random_traffic(random_cfg(1'b0), 1'b0, 25);
      test_random_traffic('0, 1'b0, 20);
      req_push <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
